// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the sorted min priority queue: sizes, status codes, and the
// entry and command types shared by the cell row and the top level. No dependencies.
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 48;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                    occ;
        logic                    tag;
        logic signed [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic                    ins;
        logic                    pop;
        logic                    tag;
        logic signed [KEY_W-1:0] key;
    } cmd_t;

endpackage

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// One slot of the sorted cell row: holds an entry, compares it with the broadcast
// key and takes the new item or a neighbor's entry on insert and pop. Uses spq_pkg.
module spq_cell import spq_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  cmd_t   cmd_i,
    input  entry_t left_i,
    input  logic   left_lt_i,
    input  entry_t right_i,
    output entry_t ent_o,
    output logic   lt_o
);

    logic                    occ_reg, occ_next;
    logic                    tag_reg, tag_next;
    logic signed [KEY_W-1:0] key_reg, key_next;

    assign lt_o  = occ_reg && (key_reg < cmd_i.key);
    assign ent_o = '{occ: occ_reg, tag: tag_reg, key: key_reg};

    always_comb begin
        occ_next = occ_reg;
        tag_next = tag_reg;
        key_next = key_reg;
        if (cmd_i.ins) begin
            if (!lt_o) begin
                if (left_lt_i) begin
                    occ_next = 1'b1;
                    tag_next = cmd_i.tag;
                    key_next = cmd_i.key;
                end else begin
                    occ_next = left_i.occ;
                    tag_next = left_i.tag;
                    key_next = left_i.key;
                end
            end
        end else if (cmd_i.pop) begin
            occ_next = right_i.occ;
            tag_next = right_i.tag;
            key_next = right_i.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
        key_reg <= key_next;
    end

endmodule

// ----- rtl/sorted_min_priority_queue.sv -----
`timescale 1ns / 1ps
// Top level of the sorted min priority queue: a row of spq_cell slots kept in
// ascending order plus a registered result stage. Uses spq_pkg and spq_cell.
//
//  channel | dir | ports                        | payload
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser | insert or pop request
//  m_      | out | m_tvalid m_tready m_tdata m_tuser | status and popped key
//
// One item per cycle while s_tready is high, one result each, in the cycle after acceptance.
// Each cell does one signed 48-bit compare against the broadcast key per cycle.
// Full and empty come from the occupancy bits of the last and first cells.
// Reset empties the row at once; no clearing pass.
// A result held by m_tready low stalls input only while it waits.
module sorted_min_priority_queue import spq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [47:0] key_value
    input  logic [1:0]  s_tuser,   // [0] opcode, [1] is_real
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [1:0] status, [49:2] out_value, [55:50] zero
    output logic [0:0]  m_tuser    // [0] out_is_real
);

    entry_t             ent_w [DEPTH];
    logic [DEPTH-1:0]   lt_w;
    logic [DEPTH-1:0]   occ_vec;
    cmd_t               cmd;
    logic               s_acc;
    logic               full, empty;
    opcode_t            op;

    logic                    m_valid_reg;
    status_t                 m_status_reg, m_status_next;
    logic                    m_tag_reg, m_tag_next;
    logic signed [KEY_W-1:0] m_value_reg, m_value_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign op       = opcode_t'(s_tuser[0]);
    assign full     = ent_w[DEPTH-1].occ;
    assign empty    = !ent_w[0].occ;

    always_comb begin
        cmd.ins = s_acc && (op == OP_INSERT) && !full;
        cmd.pop = s_acc && (op == OP_POP) && !empty;
        cmd.tag = s_tuser[1];
        cmd.key = s_tdata[KEY_W-1:0];
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            occ_vec[i] = ent_w[i].occ;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            entry_t left_e, right_e;
            logic   left_lt;
            if (g == 0) begin : g_first
                assign left_e  = '0;
                assign left_lt = 1'b1;
            end else begin : g_mid
                assign left_e  = ent_w[g-1];
                assign left_lt = lt_w[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_e = '0;
            end else begin : g_inner
                assign right_e = ent_w[g+1];
            end
            spq_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd_i     (cmd),
                .left_i    (left_e),
                .left_lt_i (left_lt),
                .right_i   (right_e),
                .ent_o     (ent_w[g]),
                .lt_o      (lt_w[g])
            );
        end
    endgenerate

    always_comb begin
        m_status_next = STATUS_OK;
        m_tag_next    = 1'b0;
        m_value_next  = '0;
        if (op == OP_INSERT) begin
            if (full) begin
                m_status_next = STATUS_FULL;
            end
        end else if (empty) begin
            m_status_next = STATUS_EMPTY;
        end else begin
            m_tag_next   = ent_w[0].tag;
            m_value_next = ent_w[0].key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_status_reg <= m_status_next;
            m_tag_reg    <= m_tag_next;
            m_value_reg  <= m_value_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_value_reg, m_status_reg};
    assign m_tuser  = m_tag_reg;

    // occupied cells always form a prefix of the row
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((occ_vec >> 1) & ~occ_vec) == '0)
        else $error("cell occupancy not contiguous");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (op == OP_INSERT) && full |=> m_tvalid && (m_tdata[1:0] == STATUS_FULL)
            && $stable(occ_vec))
        else $error("insert on full not rejected");

    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> m_tvalid && (m_tdata[49:2] == $past(ent_w[0].key))
            && (m_tuser[0] == $past(ent_w[0].tag)))
        else $error("pop did not return head entry");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(occ_vec))
        else $error("row changed while result stalled");

endmodule
